/* hdl/escaped_unicode_to_utf8_macros.svh */
// assertion macros used by the checker file
`ifndef ESCAPED_UNICODE_TO_UTF8_MACROS_SVH
`define ESCAPED_UNICODE_TO_UTF8_MACROS_SVH

// same-cycle implication under an active-low reset
`define EUU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("euu assertion failed");

// next-cycle implication under an active-low reset
`define EUU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("euu assertion failed");

`endif

/* hdl/euu_pkg.sv */
// shared types for the escaped unicode to utf-8 converter
package euu_pkg;

  localparam int unsigned MaxResults = 3;

  // results caused by one input byte, oldest in data[0]
  typedef struct packed {
    logic [1:0]                  cnt;
    logic [MaxResults-1:0][7:0]  data;
    logic                        err;
    logic                        last;
  } group_t;

endpackage

/* hdl/euu_front.sv */
// front end: escape decoder that turns each input byte into a group of results
module euu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_string_i,
  output logic            push_o,
  output euu_pkg::group_t group_o
);

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhSlash = 2'd1;
  localparam logic [1:0] PhHex   = 2'd2;
  localparam logic [1:0] PhDrop  = 2'd3;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [1:0] LastDigit   = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  digits_q, digits_d;
  logic [11:0] acc_q, acc_d;

  logic [4:0]  hex;
  logic        err_hit;
  logic [15:0] cp;
  logic        is_bs;

  // bit 4 flags a valid hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  assign hex   = hex_value(in_byte_i);
  assign cp    = {acc_q, hex[3:0]};
  assign is_bs = (in_byte_i == ChBackslash);

  always_comb begin
    phase_d  = phase_q;
    digits_d = digits_q;
    acc_d    = acc_q;
    push_o   = 1'b0;
    group_o  = '0;
    err_hit  = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PhIdle: begin
          if (is_bs && !end_of_string_i) begin
            phase_d = PhSlash;
          end else begin
            push_o          = 1'b1;
            group_o.cnt     = 2'd1;
            group_o.data[0] = in_byte_i;
            group_o.last    = end_of_string_i;
          end
        end
        PhSlash: begin
          if (in_byte_i == ChU) begin
            if (end_of_string_i) begin
              err_hit = 1'b1;
            end else begin
              phase_d  = PhHex;
              digits_d = '0;
              acc_d    = '0;
            end
          end else begin
            push_o          = 1'b1;
            group_o.data[0] = ChBackslash;
            if (is_bs && !end_of_string_i) begin
              // second backslash starts a fresh pending escape
              group_o.cnt = 2'd1;
            end else begin
              group_o.cnt     = 2'd2;
              group_o.data[1] = in_byte_i;
              group_o.last    = end_of_string_i;
              phase_d         = PhIdle;
            end
          end
        end
        PhHex: begin
          if (!hex[4]) begin
            err_hit = 1'b1;
          end else if (digits_q != LastDigit) begin
            if (end_of_string_i) begin
              err_hit = 1'b1;
            end else begin
              acc_d    = {acc_q[7:0], hex[3:0]};
              digits_d = digits_q + 2'd1;
            end
          end else begin
            push_o   = 1'b1;
            phase_d  = PhIdle;
            digits_d = '0;
            acc_d    = '0;
            group_o.last = end_of_string_i;
            if (cp[15:7] == '0) begin
              group_o.cnt     = 2'd1;
              group_o.data[0] = {1'b0, cp[6:0]};
            end else if (cp[15:11] == '0) begin
              group_o.cnt     = 2'd2;
              group_o.data[0] = {3'b110, cp[10:6]};
              group_o.data[1] = {2'b10, cp[5:0]};
            end else begin
              group_o.cnt     = 2'd3;
              group_o.data[0] = {4'b1110, cp[15:12]};
              group_o.data[1] = {2'b10, cp[11:6]};
              group_o.data[2] = {2'b10, cp[5:0]};
            end
          end
        end
        PhDrop: begin
          if (end_of_string_i) phase_d = PhIdle;
        end
        default: phase_d = PhIdle;
      endcase
      if (err_hit) begin
        push_o       = 1'b1;
        group_o      = '0;
        group_o.cnt  = 2'd1;
        group_o.err  = 1'b1;
        group_o.last = 1'b1;
        phase_d      = end_of_string_i ? PhIdle : PhDrop;
        digits_d     = '0;
        acc_d        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      digits_q <= '0;
      acc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
    end
  end

endmodule

/* hdl/euu_queue.sv */
// short queue of result groups between the decoder and the output stage
module euu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  euu_pkg::group_t wdata_i,
  input  logic            pop_i,
  output euu_pkg::group_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  euu_pkg::group_t        mem_q [Depth];
  logic [PtrW-1:0]        wr_q, rd_q;
  logic [CntW-1:0]        cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

/* hdl/euu_back.sv */
// back end: hands out each queued group one result beat per cycle on pop_i
module euu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  euu_pkg::group_t head_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      out_byte_o,
  output logic            bad_escape_o,
  output logic            last_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  logic       load, final_beat;
  logic [7:0] byte_q;
  logic       bad_q, last_q;

  assign final_beat = (idx_q == head_i.cnt - 2'd1);
  assign load       = !q_empty_i && (!valid_q || pop_i);
  assign q_pop_o    = load && final_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= final_beat ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.data[idx_q];
      bad_q  <= head_i.err;
      last_q <= head_i.last && final_beat;
    end
  end

  assign empty_o      = !valid_q;
  assign out_byte_o   = byte_q;
  assign bad_escape_o = bad_q;
  assign last_o       = last_q;

endmodule

/* hdl/escaped_unicode_to_utf8.sv */
// top level of the escaped unicode to utf-8 converter
// Input channel: a byte beat (in_byte_i, end_of_string_i) is taken at a clock
// edge with push_i high and full_o low. Result channel: while empty_o is low
// the oldest result (out_byte_o, bad_escape_o, last_o) is shown, and it is
// taken at an edge with pop_i high. Plain bytes pass through; a \uXXXX escape
// becomes one to three utf-8 bytes; a bad or cut-off escape gives one result
// with bad_escape_o and last_o set, and the rest of that string is dropped.
// The decoder takes one byte per cycle while full_o is low and writes the
// results it causes as one group into a QueueDepth-entry queue; the output
// stage hands out one result per cycle while pop_i is high, so sustained input
// is one byte per cycle while each byte gives at most one result, and otherwise
// it is paced by the result bytes. An input beat's first result passes through
// the queue write and then into the output register.
// When the receiver stalls the result holds; the queue fills and full_o rises
// after QueueDepth groups are waiting. Reset empties the queue and the output
// register and returns the decoder to its idle state, no escape pending.
module escaped_unicode_to_utf8 #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       bad_escape_o,
  output logic       last_o
);

  logic            accept;
  logic            grp_push;
  euu_pkg::group_t grp;
  euu_pkg::group_t head;
  logic            q_empty, q_pop;

  assign accept = push_i && !full_o;

  euu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .push_o          (grp_push),
    .group_o         (grp)
  );

  euu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .wdata_i (grp),
    .pop_i   (q_pop),
    .rdata_o (head),
    .full_o  (full_o),
    .empty_o (q_empty)
  );

  euu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .head_i       (head),
    .q_pop_o      (q_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .out_byte_o   (out_byte_o),
    .bad_escape_o (bad_escape_o),
    .last_o       (last_o)
  );

endmodule

/* hdl/euu_checker.sv */
// port-level checks on the converter result channel, bound to the top level
`include "escaped_unicode_to_utf8_macros.svh"

module euu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty_o,
  input logic       pop_i,
  input logic [7:0] out_byte_o,
  input logic       bad_escape_o,
  input logic       last_o
);

  // all fields of the result beat, for the hold check
  logic [9:0] beat;

  assign beat = {out_byte_o, bad_escape_o, last_o};

  // an error beat always closes its string
  `EUU_ASSERT_NOW(a_err_last, clk_i, rst_ni, !empty_o && bad_escape_o, last_o)

  // an error beat carries a zero byte
  `EUU_ASSERT_NOW(a_err_zero, clk_i, rst_ni, !empty_o && bad_escape_o, out_byte_o == 8'd0)

  // a stalled result beat holds
  `EUU_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty_o && !pop_i, !empty_o && $stable(beat))

endmodule

bind escaped_unicode_to_utf8 euu_checker u_checker (.*);
